>>> rtl/ptrt_pkg.sv
`default_nettype none
package ptrt_pkg;

    localparam int TIME_W       = 32;
    localparam int SLOT_W       = 3;
    localparam int RESULT_LIMIT = 8;
    localparam int N_W          = 4;
    localparam int CQ_DEPTH     = 2;
    localparam int CQ_AW        = 1;
    localparam int RQ_DEPTH     = 4;
    localparam int RQ_AW        = 2;

    typedef enum logic [1:0] {
        K_ADD      = 2'd0,
        K_SET      = 2'd1,
        K_DISPATCH = 2'd2,
        K_QUERY    = 2'd3
    } t_kind;

    // stamp holds now + delay for an add and now for everything else
    typedef struct packed {
        t_kind              kind;
        logic               per_zero;
        logic [TIME_W-1:0]  stamp;
        logic [TIME_W-1:0]  period;
        logic [SLOT_W-1:0]  idx;
    } t_cmd;

    typedef struct packed {
        logic [SLOT_W-1:0]  slot;
        logic               status;
        logic [TIME_W-1:0]  period;
        logic [TIME_W-1:0]  count;
        logic               last;
    } t_res;

    typedef struct packed {
        logic [TIME_W-1:0]  period;
        logic [TIME_W-1:0]  rel_ms;
        logic [TIME_W-1:0]  count;
    } t_row;

endpackage
`default_nettype wire

>>> rtl/ptrt_front.sv
`default_nettype none
module ptrt_front
    import ptrt_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    output logic                    o_full,
    input  wire logic [1:0]         i_kind,
    input  wire logic [TIME_W-1:0]  i_now_ms,
    input  wire logic [TIME_W-1:0]  i_delay_ms,
    input  wire logic [TIME_W-1:0]  i_period_ms,
    input  wire logic [SLOT_W-1:0]  i_task_index,
    output logic                    o_valid,
    output t_cmd                    o_cmd,
    input  wire logic               i_pop
);

    t_cmd               cmd;
    t_cmd               r_q [CQ_DEPTH];
    logic [CQ_AW-1:0]   r_wp, n_wp;
    logic [CQ_AW-1:0]   r_rp, n_rp;
    logic [CQ_AW:0]     r_cnt, n_cnt;
    logic               wr, rd;

    // classify the item before it is queued
    always_comb begin
        cmd.kind     = t_kind'(i_kind);
        cmd.per_zero = (i_period_ms == '0);
        cmd.period   = i_period_ms;
        cmd.idx      = i_task_index;
        if (t_kind'(i_kind) == K_ADD) begin
            cmd.stamp = i_now_ms + i_delay_ms;
        end else begin
            cmd.stamp = i_now_ms;
        end
    end

    assign o_full  = (r_cnt == (CQ_AW+1)'(CQ_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_q[r_rp];
    assign wr      = i_push && !o_full;
    assign rd      = i_pop && o_valid;

    always_comb begin
        n_wp  = wr ? r_wp + CQ_AW'(1) : r_wp;
        n_rp  = rd ? r_rp + CQ_AW'(1) : r_rp;
        n_cnt = r_cnt + (CQ_AW+1)'(wr) - (CQ_AW+1)'(rd);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_q[r_wp] <= cmd;
        end
    end

endmodule
`default_nettype wire

>>> rtl/ptrt_exec.sv
`default_nettype none
module ptrt_exec
    import ptrt_pkg::*;
#(
    parameter int MAX_TASKS = 8
)
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_valid,
    input  wire t_cmd   i_cmd,
    output logic        o_pop,
    output logic        o_push,
    output t_res        o_res,
    input  wire logic   i_space
);

    localparam int SW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int UW = $clog2(MAX_TASKS + 1);
    localparam int CW = ((SW > SLOT_W) ? SW : SLOT_W) + 1;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_EXEC  = 4'b0010,
        S_WALK  = 4'b0100,
        S_FLUSH = 4'b1000
    } t_state;

    t_state                 r_state, n_state;
    t_cmd                   r_cmd;
    logic [UW-1:0]          r_used, n_used;
    logic [MAX_TASKS-1:0]   r_active;
    logic [SW-1:0]          r_idx, n_idx;
    logic [N_W-1:0]         r_n, n_n;
    logic                   r_pend_v, n_pend_v;
    t_res                   r_pend, n_pend;
    t_row                   r_mem [MAX_TASKS];
    t_row                   r_rdata;

    logic [SW-1:0]          rd_addr, wr_addr;
    logic                   we, set_active;
    t_row                   wdata;
    logic [CW-1:0]          in_idx_ext, cmd_idx_ext, used_ext, walk_ext;
    logic                   idx_ok, add_ok, due, last_slot, hit_limit;
    logic [TIME_W-1:0]      diff;

    assign in_idx_ext  = CW'(i_cmd.idx);
    assign cmd_idx_ext = CW'(r_cmd.idx);
    assign used_ext    = CW'(r_used);
    assign walk_ext    = CW'(r_idx);
    assign idx_ok      = cmd_idx_ext < used_ext;
    assign add_ok      = (used_ext < CW'(MAX_TASKS)) && !r_cmd.per_zero;
    // wrap-safe: due when now - release is not negative
    assign diff        = r_cmd.stamp - r_rdata.rel_ms;
    assign due         = r_active[r_idx] && !diff[TIME_W-1];
    assign last_slot   = (walk_ext + CW'(1)) == used_ext;
    assign hit_limit   = (r_n + N_W'(1)) == N_W'(RESULT_LIMIT);

    always_comb begin
        n_state    = r_state;
        n_used     = r_used;
        n_idx      = r_idx;
        n_n        = r_n;
        n_pend_v   = r_pend_v;
        n_pend     = r_pend;
        rd_addr    = r_idx;
        wr_addr    = r_idx;
        we         = 1'b0;
        set_active = 1'b0;
        wdata      = r_rdata;
        o_pop      = 1'b0;
        o_push     = 1'b0;
        o_res      = '0;
        case (r_state)
            S_IDLE: begin
                rd_addr = in_idx_ext[SW-1:0];
                if (i_valid) begin
                    o_pop = 1'b1;
                    if (i_cmd.kind == K_DISPATCH) begin
                        rd_addr  = '0;
                        n_idx    = '0;
                        n_n      = '0;
                        n_pend_v = 1'b0;
                        if (r_used != '0) begin
                            n_state = S_WALK;
                        end
                    end else begin
                        n_state = S_EXEC;
                    end
                end
            end
            S_EXEC: begin
                // keep the addressed row in r_rdata while the result queue is full
                rd_addr = cmd_idx_ext[SW-1:0];
                if (i_space) begin
                    o_push     = 1'b1;
                    o_res.last = 1'b1;
                    n_state    = S_IDLE;
                    case (r_cmd.kind)
                        K_ADD: begin
                            if (add_ok) begin
                                o_res.slot   = used_ext[SLOT_W-1:0];
                                o_res.period = r_cmd.period;
                                wr_addr      = r_used[SW-1:0];
                                we           = 1'b1;
                                set_active   = 1'b1;
                                wdata.period = r_cmd.period;
                                wdata.rel_ms = r_cmd.stamp;
                                wdata.count  = '0;
                                n_used       = r_used + UW'(1);
                            end else begin
                                o_res.status = 1'b1;
                            end
                        end
                        K_SET, K_QUERY: begin
                            o_res.slot = r_cmd.idx;
                            wr_addr    = cmd_idx_ext[SW-1:0];
                            if (!idx_ok) begin
                                o_res.status = 1'b1;
                            end else begin
                                o_res.period = r_rdata.period;
                                o_res.count  = r_rdata.count;
                                if (r_cmd.kind == K_SET) begin
                                    if (r_cmd.per_zero) begin
                                        o_res.status = 1'b1;
                                    end else begin
                                        we           = 1'b1;
                                        wdata.period = r_cmd.period;
                                        o_res.period = r_cmd.period;
                                    end
                                end
                            end
                        end
                        default: begin
                            o_push = 1'b0;
                        end
                    endcase
                end
            end
            S_WALK: begin
                // r_rdata holds slot r_idx; next slot is read while this one updates
                if (i_space) begin
                    if (due) begin
                        we           = 1'b1;
                        wdata.rel_ms = r_rdata.rel_ms + r_rdata.period;
                        wdata.count  = r_rdata.count + TIME_W'(1);
                        n_n          = r_n + N_W'(1);
                        o_push       = r_pend_v;
                        o_res        = r_pend;
                        o_res.last   = 1'b0;
                        n_pend_v     = 1'b1;
                        n_pend.slot   = walk_ext[SLOT_W-1:0];
                        n_pend.status = 1'b0;
                        n_pend.period = r_rdata.period;
                        n_pend.count  = r_rdata.count + TIME_W'(1);
                        n_pend.last   = 1'b1;
                    end
                    if (last_slot || (due && hit_limit)) begin
                        n_state = S_FLUSH;
                    end else begin
                        n_idx   = r_idx + SW'(1);
                        rd_addr = r_idx + SW'(1);
                    end
                end
            end
            S_FLUSH: begin
                if (!r_pend_v) begin
                    n_state = S_IDLE;
                end else if (i_space) begin
                    o_push   = 1'b1;
                    o_res    = r_pend;
                    n_pend_v = 1'b0;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_used   <= '0;
            r_active <= '0;
            r_idx    <= '0;
            r_n      <= '0;
            r_pend_v <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_used   <= n_used;
            r_idx    <= n_idx;
            r_n      <= n_n;
            r_pend_v <= n_pend_v;
            if (set_active) begin
                r_active[wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend <= n_pend;
        if (o_pop) begin
            r_cmd <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[wr_addr] <= wdata;
        end
        r_rdata <= r_mem[rd_addr];
    end

    a_push_space: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> i_space)
        else $error("result pushed into a full queue");

    a_no_push_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> (r_state != S_IDLE))
        else $error("result pushed while idle");

    a_walk_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (walk_ext < used_ext))
        else $error("walk beyond used slots");

    a_add_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC && r_cmd.kind == K_ADD && add_ok && i_space)
        |=> (r_used == $past(r_used) + UW'(1)))
        else $error("accepted add did not take a slot");

    a_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (r_n < N_W'(RESULT_LIMIT)))
        else $error("release count over limit during walk");

endmodule
`default_nettype wire

>>> rtl/ptrt_rqueue.sv
`default_nettype none
module ptrt_rqueue
    import ptrt_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire t_res   i_res,
    output logic        o_space,
    output logic        o_empty,
    output t_res        o_res,
    input  wire logic   i_pop
);

    t_res               r_q [RQ_DEPTH];
    logic [RQ_AW-1:0]   r_wp, n_wp;
    logic [RQ_AW-1:0]   r_rp, n_rp;
    logic [RQ_AW:0]     r_cnt, n_cnt;
    logic               wr, rd;

    assign o_space = (r_cnt != (RQ_AW+1)'(RQ_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_res   = r_q[r_rp];
    assign wr      = i_push && o_space;
    assign rd      = i_pop && !o_empty;

    always_comb begin
        n_wp  = wr ? r_wp + RQ_AW'(1) : r_wp;
        n_rp  = rd ? r_rp + RQ_AW'(1) : r_rp;
        n_cnt = r_cnt + (RQ_AW+1)'(wr) - (RQ_AW+1)'(rd);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_q[r_wp] <= i_res;
        end
    end

endmodule
`default_nettype wire

>>> rtl/periodic_task_release_table_core.sv
// Add, set period and query: the executor pops a command and does a registered read of its slot,
// then pushes the result and writes any update through the separate write port of the table.
// Dispatch: one slot per cycle while the result queue has space, results streaming out, up to RESULT_LIMIT.
// A 2-entry command queue and a 4-entry result queue let input and output stall independently.
// Reset (synchronous, active low) clears queues, active flags and the slot fill count;
// slot table contents are not cleared and there is no clearing pass.
`default_nettype none
module periodic_task_release_table_core
    import ptrt_pkg::*;
#(
    parameter int MAX_TASKS = 8
)
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire logic [1:0]         i_kind,
    input  wire logic [TIME_W-1:0]  i_now_ms,
    input  wire logic [TIME_W-1:0]  i_delay_ms,
    input  wire logic [TIME_W-1:0]  i_period_ms,
    input  wire logic [SLOT_W-1:0]  i_task_index,
    output logic                    empty,
    input  wire logic               pop,
    output logic [SLOT_W-1:0]       o_slot,
    output logic                    o_status,
    output logic [TIME_W-1:0]       o_period_out,
    output logic [TIME_W-1:0]       o_count_out,
    output logic                    o_last
);

    logic   cmd_valid, cmd_pop, res_push, res_space;
    t_cmd   cmd;
    t_res   res_in, res_out;

    ptrt_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_full       (full),
        .i_kind       (i_kind),
        .i_now_ms     (i_now_ms),
        .i_delay_ms   (i_delay_ms),
        .i_period_ms  (i_period_ms),
        .i_task_index (i_task_index),
        .o_valid      (cmd_valid),
        .o_cmd        (cmd),
        .i_pop        (cmd_pop)
    );

    ptrt_exec #(
        .MAX_TASKS (MAX_TASKS)
    ) u_exec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (cmd_valid),
        .i_cmd   (cmd),
        .o_pop   (cmd_pop),
        .o_push  (res_push),
        .o_res   (res_in),
        .i_space (res_space)
    );

    ptrt_rqueue u_rqueue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_res   (res_in),
        .o_space (res_space),
        .o_empty (empty),
        .o_res   (res_out),
        .i_pop   (pop)
    );

    assign o_slot       = res_out.slot;
    assign o_status     = res_out.status;
    assign o_period_out = res_out.period;
    assign o_count_out  = res_out.count;
    assign o_last       = res_out.last;

endmodule
`default_nettype wire
